@@ sv/vm_operand_stack_core_macros.svh @@
// assertion helpers for the operand stack core
`ifndef VM_OPERAND_STACK_CORE_MACROS_SVH
`define VM_OPERAND_STACK_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define VMOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define VMOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/vmos_pkg.sv @@
package vmos_pkg;

  // default number of stack entries
  localparam int unsigned STACK_DEPTH_DEF = 512;

  // fixed field widths
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned FP_W    = 9;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned ST_W    = 2;

  // stack operations
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_DUP   = 3'd2,
    ACT_SWAP  = 3'd3,
    ACT_LOAD  = 3'd4,
    ACT_STORE = 3'd5
  } action_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

@@ sv/vm_operand_stack_core.sv @@
// operand stack core: accepts one operation per cycle when the output side keeps up
// path: an accepted beat is held in the input register until it executes into the result register
// throughput: one beat per cycle without output stalls; top and next entries live in registers,
//   the rest in a memory; one write port, two read ports prefetch the entries an op may need
// reset: depth, frame pointer and handshake state clear at once; memory contents are not cleared
`include "vm_operand_stack_core_macros.svh"

module vm_operand_stack_core #(
  parameter int unsigned STACK_DEPTH = vmos_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // operation channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [vmos_pkg::ACT_W-1:0]          action_i,
  input  logic signed [vmos_pkg::VAL_W-1:0]   push_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vmos_pkg::VAL_W-1:0]   result_value_o,
  output logic [vmos_pkg::DEPTH_W-1:0]        stack_depth_o,
  output logic [vmos_pkg::ST_W-1:0]           status_o,
  // frame pointer register
  input  logic                                cfg_we_i,
  input  logic [vmos_pkg::FP_W-1:0]           cfg_wdata_i
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW = vmos_pkg::VAL_W;
  localparam int unsigned FW = vmos_pkg::FP_W;
  localparam int unsigned DW = vmos_pkg::DEPTH_W;

  // handshake and control
  logic           in_valid_q;
  logic           out_valid_q;
  logic           exec_fire;
  logic           in_accept;

  // input register
  logic [vmos_pkg::ACT_W-1:0] act_q;
  logic [VW-1:0]  pv_q;

  // architectural state
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [FW-1:0]  fp_q;
  logic [VW-1:0]  tos_q, tos_d;
  logic [VW-1:0]  nos_q, nos_d;

  // result register
  logic [VW-1:0]  out_val_q;
  logic [DW-1:0]  out_depth_q;
  logic [vmos_pkg::ST_W-1:0] out_status_q;

  // memory and read ports
  logic [VW-1:0]  mem_q [STACK_DEPTH];
  logic [AW-1:0]  raddr_a, raddr_b;
  logic [VW-1:0]  rda_mem_q, rdb_mem_q;
  logic           byp_a_hit_q, byp_b_hit_q;
  logic [VW-1:0]  byp_a_q, byp_b_q;
  logic [VW-1:0]  rd_a, rd_b;
  logic           mem_we;

  // execute signals
  logic [CW-1:0]  cnt_m1, cnt_m2, cnt_m3, cnt_m4;
  logic [VW-1:0]  fsum_t, fsum_n;
  logic           is_empty, is_full, lt_two;
  logic           load_ok, store_ok;
  logic [CW-1:0]  ld_idx, st_idx;
  logic [VW-1:0]  t_new, n_new;
  logic [CW-1:0]  c_new;
  vmos_pkg::status_e st;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [VW-1:0]  wr_data;
  logic           pop_ok;
  logic [VW-1:0]  res_val;
  logic [CW+DW-1:0] depth_ext;
  logic [AW+FW-1:0] fp_ext;
  logic           fail_fire, push_fire;

  // handshake
  assign exec_fire  = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !exec_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (exec_fire) begin
        in_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input beat register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= action_i;
      pv_q  <= push_value_i;
    end
  end

  // read data with write bypass
  assign rd_a = byp_a_hit_q ? byp_a_q : rda_mem_q;
  assign rd_b = byp_b_hit_q ? byp_b_q : rdb_mem_q;

  // operand arithmetic
  assign cnt_m1   = cnt_q - CW'(1);
  assign cnt_m2   = cnt_q - CW'(2);
  assign cnt_m3   = cnt_q - CW'(3);
  assign cnt_m4   = cnt_q - CW'(4);
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q == CW'(STACK_DEPTH));
  assign lt_two   = (cnt_q < CW'(2));
  assign fsum_t   = VW'(fp_q) + tos_q;
  assign fsum_n   = VW'(fp_q) + nos_q;
  assign load_ok  = (fsum_t < VW'(cnt_m1));
  assign store_ok = (fsum_n < VW'(cnt_m2));
  assign ld_idx   = fsum_t[CW-1:0];
  assign st_idx   = fsum_n[CW-1:0];

  // execute one operation
  always_comb begin
    t_new   = tos_q;
    n_new   = nos_q;
    c_new   = cnt_q;
    st      = vmos_pkg::ST_OK;
    wr_en   = 1'b0;
    wr_addr = cnt_m2[AW-1:0];
    wr_data = nos_q;
    pop_ok  = 1'b0;
    unique case (act_q)
      vmos_pkg::ACT_PUSH: begin
        if (is_full) begin
          st = vmos_pkg::ST_OVER;
        end else begin
          wr_en = !lt_two;
          n_new = tos_q;
          t_new = pv_q;
          c_new = cnt_q + CW'(1);
        end
      end
      vmos_pkg::ACT_POP: begin
        if (is_empty) begin
          st = vmos_pkg::ST_UNDER;
        end else begin
          t_new  = nos_q;
          n_new  = rd_a;
          c_new  = cnt_m1;
          pop_ok = 1'b1;
        end
      end
      vmos_pkg::ACT_DUP: begin
        if (is_empty) begin
          st = vmos_pkg::ST_UNDER;
        end else if (is_full) begin
          st = vmos_pkg::ST_OVER;
        end else begin
          wr_en = !lt_two;
          n_new = tos_q;
          c_new = cnt_q + CW'(1);
        end
      end
      vmos_pkg::ACT_SWAP: begin
        if (lt_two) begin
          st = vmos_pkg::ST_UNDER;
        end else begin
          t_new = nos_q;
          n_new = tos_q;
        end
      end
      vmos_pkg::ACT_LOAD: begin
        if (is_empty) begin
          st = vmos_pkg::ST_UNDER;
        end else if (!load_ok) begin
          st = vmos_pkg::ST_RANGE;
        end else begin
          // the next entry sits in a register, everything lower in memory
          t_new = (ld_idx == cnt_m2) ? nos_q : rd_b;
        end
      end
      vmos_pkg::ACT_STORE: begin
        if (lt_two) begin
          st = vmos_pkg::ST_UNDER;
        end else if (!store_ok) begin
          st = vmos_pkg::ST_RANGE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = st_idx[AW-1:0];
          wr_data = tos_q;
          // refill top and next, taking the stored value where it lands there
          t_new   = (st_idx == cnt_m3) ? tos_q : rd_a;
          n_new   = (st_idx == cnt_m4) ? tos_q : rd_b;
          c_new   = cnt_m2;
        end
      end
      default: begin
      end
    endcase
  end

  // result value: popped entry, else new top or zero when empty
  assign res_val   = pop_ok ? tos_q : ((c_new == '0) ? '0 : t_new);
  assign depth_ext = (CW+DW)'(c_new);

  // next state
  assign cnt_d  = exec_fire ? c_new : cnt_q;
  assign tos_d  = exec_fire ? t_new : tos_q;
  assign nos_d  = exec_fire ? n_new : nos_q;
  assign mem_we = exec_fire && wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fp_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        fp_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    nos_q <= nos_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_val_q    <= res_val;
      out_depth_q  <= depth_ext[DW-1:0];
      out_status_q <= st;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign stack_depth_o  = out_depth_q;
  assign status_o       = out_status_q;

  // prefetch addresses for the incoming beat, taken from the state after the current op
  assign fp_ext  = (AW+FW)'(fp_q);
  assign raddr_a = AW'(cnt_d - CW'(3));
  always_comb begin
    if (action_i == vmos_pkg::ACT_LOAD) begin
      raddr_b = fp_ext[AW-1:0] + tos_d[AW-1:0];
    end else begin
      raddr_b = AW'(cnt_d - CW'(4));
    end
  end

  // stack memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // stack memory read ports, captured with the input beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rda_mem_q <= mem_q[raddr_a];
      rdb_mem_q <= mem_q[raddr_b];
      byp_a_q   <= wr_data;
      byp_b_q   <= wr_data;
    end
  end

  // bypass flags for a write to the address being read at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_a_hit_q <= 1'b0;
      byp_b_hit_q <= 1'b0;
    end else if (in_accept) begin
      byp_a_hit_q <= mem_we && (wr_addr == raddr_a);
      byp_b_hit_q <= mem_we && (wr_addr == raddr_b);
    end
  end

  // checks
  assign fail_fire = exec_fire && (st != vmos_pkg::ST_OK);
  assign push_fire = exec_fire && (act_q == vmos_pkg::ACT_PUSH) && (st == vmos_pkg::ST_OK);

  `VMOS_ASSERT_IMP(a_depth_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH), "stack depth above capacity")
  `VMOS_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_q && out_stall_i, "stray input stall")
  `VMOS_ASSERT_NXT(a_fail_keeps, fail_fire, cnt_q == $past(cnt_q), "failed op changed depth")
  `VMOS_ASSERT_NXT(a_push_grows, push_fire, cnt_q == $past(cnt_q) + CW'(1), "push did not grow")

endmodule
